// ===== rtl/pl0_pkg.sv =====
`timescale 1ns / 1ps
package pl0_pkg;
  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_WRT = 4'd9;
  localparam logic [3:0] OP_RED = 4'd10;

  localparam logic [3:0] OPR_RET = 4'd0;
  localparam logic [3:0] OPR_NEG = 4'd1;
  localparam logic [3:0] OPR_ADD = 4'd2;
  localparam logic [3:0] OPR_SUB = 4'd3;
  localparam logic [3:0] OPR_MUL = 4'd4;
  localparam logic [3:0] OPR_DIV = 4'd5;
  localparam logic [3:0] OPR_ODD = 4'd6;
  localparam logic [3:0] OPR_MOD = 4'd7;
  localparam logic [3:0] OPR_EQL = 4'd8;
  localparam logic [3:0] OPR_NEQ = 4'd9;
  localparam logic [3:0] OPR_LSS = 4'd10;
  localparam logic [3:0] OPR_LEQ = 4'd11;
  localparam logic [3:0] OPR_GTR = 4'd12;
  localparam logic [3:0] OPR_GEQ = 4'd13;

  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

// ===== rtl/pl0_div.sv =====
`timescale 1ns / 1ps
// signed restoring divider, one quotient bit per cycle, truncating toward zero
module pl0_div
  import pl0_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] q;
  logic [32:0] r;
  logic [31:0] d;
  logic        nq;
  logic        nr;
  logic [32:0] trial;
  logic [31:0] q_out;
  logic [31:0] r_out;

  assign trial = {r[31:0], q[31]} - {1'b0, d};
  assign q_out = nq ? 32'(-q) : q;
  assign r_out = nr ? 32'(-r[31:0]) : r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        q    <= req.num[31] ? 32'(-req.num) : req.num;
        d    <= req.den[31] ? 32'(-req.den) : req.den;
        r    <= '0;
        nq   <= req.num[31] ^ req.den[31];
        nr   <= req.num[31];
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo  <= q_out;
          rsp.rem  <= r_out;
        end else begin
          cnt <= cnt - 6'd1;
          if (!trial[32]) begin
            r <= trial;
            q <= {q[30:0], 1'b1};
          end else begin
            r <= {r[31:0], q[31]};
            q <= {q[30:0], 1'b0};
          end
        end
      end
    end
  end
endmodule

// ===== rtl/pl0_stack_machine_execute.sv =====
`timescale 1ns / 1ps
// Sequencing: lod/sto/cal first walk up to three static links, div/mod wait on the divider,
//   and once halted each transaction only rereads the top of stack.
// One transaction in flight; the next is taken the cycle after the result is accepted.
// Each stack read goes through an address step, the RAM read and registered data on the stack RAM.
// Reset: pc 0, bp 1, sp 0, not halted; then a clearing pass zeroes every word of the
//   stack RAM, during which no transaction is accepted.
module pl0_stack_machine_execute
  import pl0_pkg::*;
#(
  parameter int STACK_DEPTH = 2048,
  parameter int CODE_DEPTH  = 512,
  parameter int MAX_LEVEL   = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3:0]                     opcode,
  input  logic [1:0]                     level,
  input  logic signed [31:0]             modifier,
  input  logic signed [31:0]             read_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [$clog2(CODE_DEPTH)-1:0]  next_pc,
  output logic [$clog2(STACK_DEPTH)-1:0] base_now,
  output logic [$clog2(STACK_DEPTH)-1:0] top_index,
  output logic signed [31:0]             top_value,
  output logic                           write_valid,
  output logic signed [31:0]             write_value,
  output logic                           halted,
  output logic                           fault
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(CODE_DEPTH);
  // signed working width, room for address sums with a 32-bit modifier
  localparam int XW = 34;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;  // issue read
  localparam logic [3:0] S_RW   = 4'd3;  // read data arrives
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;  // write sequence
  localparam logic [3:0] S_TOP  = 4'd6;  // read top of stack
  localparam logic [3:0] S_TOPW = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_RWT  = 4'd9;  // RAM read in progress

  // purpose of the current read
  localparam logic [2:0] R_WALK = 3'd0;  // static link
  localparam logic [2:0] R_Y    = 3'd1;  // stack[sp]
  localparam logic [2:0] R_X    = 3'd2;  // stack[sp-1]
  localparam logic [2:0] R_VAR  = 3'd3;  // stack[b+m]
  localparam logic [2:0] R_RA   = 3'd4;  // return address
  localparam logic [2:0] R_DL   = 3'd5;  // dynamic link

  logic [3:0] state;

  // stack RAM
  logic [31:0] mem [STACK_DEPTH];
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [PW-1:0] pc;
  logic [AW-1:0] bp;
  logic [AW-1:0] sp;
  logic          stopped;
  logic [AW:0]   clr;

  // latched instruction
  logic [3:0]  op;
  logic [1:0]  lv_left;
  logic signed [31:0] m;
  logic [31:0] rd_val;

  logic signed [XW-1:0] b;     // walk base
  logic [2:0]  rkind;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] res;
  logic [31:0] ra;
  logic [1:0]  wstep;
  logic        flt;

  logic [PW-1:0] pc_seq;
  assign pc_seq = (pc == PW'(CODE_DEPTH - 1)) ? '0 : pc + PW'(1);

  function automatic logic in_stk(input logic signed [XW-1:0] v);
    return v >= 0 && v < XW'(STACK_DEPTH);
  endfunction
  function automatic logic in_cod(input logic signed [XW-1:0] v);
    return v >= 0 && v < XW'(CODE_DEPTH);
  endfunction

  logic signed [XW-1:0] spx, bpx, mx;
  assign spx = XW'({1'b0, sp});
  assign bpx = XW'({1'b0, bp});
  assign mx  = XW'(m);

  logic signed [XW-1:0] rdx;
  assign rdx = XW'($signed(rdata));

  // divider
  div_req_t dreq;
  div_rsp_t drsp;
  pl0_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [63:0] prod;
  assign prod = x * y;

  logic signed [31:0] sx, sy;
  assign sx = $signed(x);
  assign sy = $signed(y);
  logic [3:0] sub;
  assign sub = m[3:0];

  assign in_ready = (state == S_IDLE) && !out_valid;

  logic signed [XW-1:0] vaddr;
  assign vaddr = b + mx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      pc        <= '0;
      bp        <= AW'(1);
      sp        <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
      we        <= 1'b0;
    end else begin
      we <= 1'b0;
      dreq.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          we    <= 1'b1;
          waddr <= clr[AW-1:0];
          wdata <= '0;
          clr   <= clr + 1'b1;
          if (clr == (AW+1)'(STACK_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op      <= opcode;
            m       <= modifier;
            rd_val  <= read_value;
            lv_left <= level;
            b       <= bpx;
            flt     <= 1'b0;
            write_valid <= 1'b0;
            write_value <= '0;
            wstep   <= '0;
            if (stopped) begin
              state <= S_TOP;
            end else begin
              // first decision: which read, if any
              state <= S_RD;
              case (opcode)
                OP_LOD, OP_STO, OP_CAL: rkind <= (level != 2'd0) ? R_WALK : R_Y;
                OP_OPR: rkind <= (modifier == 32'sd0) ? R_RA : R_Y;
                default: rkind <= R_Y;
              endcase
              if (32'(level) > 32'(MAX_LEVEL) &&
                  (opcode == OP_LOD || opcode == OP_STO || opcode == OP_CAL)) begin
                // bad level
                pc <= pc_seq; flt <= 1'b1; state <= S_TOP;
              end
            end
          end
        end
        S_RD: begin
          // range checks and read address
          state <= S_RWT;
          case (rkind)
            R_WALK: begin
              if (!in_stk(b) || !in_stk(b + 1)) begin
                pc <= pc_seq; flt <= 1'b1; state <= S_TOP;
              end
              raddr <= AW'(b + 1);
            end
            R_RA: begin
              if (!in_stk(bpx + 3) || !in_stk(bpx - 1)) begin
                pc <= pc_seq; flt <= 1'b1; state <= S_TOP;
              end
              raddr <= AW'(bpx + 3);
            end
            R_DL: raddr <= AW'(bpx + 2);
            R_X:  raddr <= AW'(spx - 1);
            R_VAR: raddr <= AW'(vaddr);
            default: raddr <= sp;
          endcase
        end
        S_RWT: state <= S_RW;
        S_RW: begin
          state <= S_RD;
          case (rkind)
            R_WALK: begin
              b <= rdx;
              lv_left <= lv_left - 2'd1;
              if (lv_left == 2'd1) rkind <= R_Y;
            end
            R_RA: begin
              ra <= rdata;
              rkind <= R_DL;
            end
            R_DL: begin
              if (!in_cod(XW'($signed(ra))) || !in_stk(rdx)) begin
                pc <= pc_seq; flt <= 1'b1;
              end else begin
                pc <= PW'(ra);
                bp <= AW'(rdx);
                sp <= AW'(bpx - 1);
              end
              state <= S_TOP;
            end
            R_VAR: begin
              // lod
              y <= rdata;
              state <= S_WR;
            end
            R_X: begin
              x <= rdata;
              if (sub == OPR_DIV || sub == OPR_MOD) begin
                if (y == 32'd0) begin
                  flt <= 1'b1; res <= '0; state <= S_WR;
                end else begin
                  dreq.start <= 1'b1; dreq.num <= rdata; dreq.den <= y;
                  dreq.is_mod <= (sub == OPR_MOD);
                  state <= S_DIV;
                end
              end else begin
                state <= S_WR;
              end
            end
            default: begin
              // R_Y: stack[sp] in hand; b is final walk base
              y <= rdata;
              state <= S_WR;
              case (op)
                OP_LIT, OP_RED: begin
                  if (!in_stk(spx + 1)) begin pc <= pc_seq; flt <= 1'b1; state <= S_TOP; end
                end
                OP_OPR: begin
                  if (m >= 32'sd2 && m <= 32'sd13 && m != 32'sd6) begin
                    if (!in_stk(spx - 1)) begin
                      pc <= pc_seq; flt <= 1'b1; state <= S_TOP;
                    end else begin
                      rkind <= R_X; state <= S_RD;
                    end
                  end
                end
                OP_LOD, OP_STO: begin
                  if (!in_stk(b) || !in_stk(vaddr) ||
                      !in_stk(op == OP_LOD ? spx + 1 : spx - 1)) begin
                    pc <= pc_seq; flt <= 1'b1; state <= S_TOP;
                  end else if (op == OP_LOD) begin
                    rkind <= R_VAR; state <= S_RD;
                  end
                end
                OP_CAL: begin
                  if (!in_stk(b) || !in_stk(spx + 4) || !in_cod(mx)) begin
                    pc <= pc_seq; flt <= 1'b1; state <= S_TOP;
                  end
                end
                OP_INC: begin
                  if (!in_stk(spx + mx)) begin pc <= pc_seq; flt <= 1'b1; state <= S_TOP; end
                end
                OP_JMP: begin
                  if (!in_cod(mx)) begin pc <= pc_seq; flt <= 1'b1; state <= S_TOP; end
                end
                OP_JPC, OP_WRT: begin
                  if (!in_stk(spx - 1) || (op == OP_JPC && rdata == 32'd0 && !in_cod(mx)))
                  begin
                    pc <= pc_seq; flt <= 1'b1; state <= S_TOP;
                  end
                end
                default: ;
              endcase
            end
          endcase
        end
        S_DIV: begin
          if (drsp.done) begin
            res <= dreq.is_mod ? drsp.rem : drsp.quo;
            state <= S_WR;
          end
        end
        S_WR: begin
          state <= S_TOP;
          pc <= pc_seq;
          case (op)
            OP_LIT: begin
              we <= 1'b1; waddr <= AW'(spx + 1); wdata <= m; sp <= AW'(spx + 1);
            end
            OP_RED: begin
              we <= 1'b1; waddr <= AW'(spx + 1); wdata <= rd_val; sp <= AW'(spx + 1);
            end
            OP_LOD: begin
              we <= 1'b1; waddr <= AW'(spx + 1); wdata <= y; sp <= AW'(spx + 1);
            end
            OP_STO: begin
              we <= 1'b1; waddr <= AW'(vaddr); wdata <= y; sp <= AW'(spx - 1);
            end
            OP_INC: sp <= AW'(spx + mx);
            OP_JMP: pc <= PW'(m);
            OP_JPC: begin
              if (y == 32'd0) pc <= PW'(m);
              sp <= AW'(spx - 1);
            end
            OP_WRT: begin
              write_valid <= 1'b1; write_value <= y; sp <= AW'(spx - 1);
            end
            OP_CAL: begin
              // four writes to the new frame
              we    <= 1'b1;
              waddr <= AW'(spx + 1 + XW'(wstep));
              case (wstep)
                2'd0: wdata <= '0;
                2'd1: wdata <= 32'(b);
                2'd2: wdata <= 32'(bp);
                default: wdata <= 32'(pc_seq);
              endcase
              wstep <= wstep + 2'd1;
              if (wstep != 2'd3) begin
                state <= S_WR; pc <= pc;
              end else begin
                bp <= AW'(spx + 1); pc <= PW'(m);
              end
            end
            OP_OPR: begin
              if (m == 32'sd1 || m == 32'sd6) begin
                we <= 1'b1; waddr <= sp;
                wdata <= (m == 32'sd1) ? 32'(-y) : (y & 32'd1);
              end else if (m >= 32'sd2 && m <= 32'sd13) begin
                we <= 1'b1; waddr <= AW'(spx - 1); sp <= AW'(spx - 1);
                case (sub)
                  OPR_ADD: wdata <= x + y;
                  OPR_SUB: wdata <= x - y;
                  OPR_MUL: wdata <= prod[31:0];
                  OPR_EQL: wdata <= 32'(sx == sy);
                  OPR_NEQ: wdata <= 32'(sx != sy);
                  OPR_LSS: wdata <= 32'(sx < sy);
                  OPR_LEQ: wdata <= 32'(sx <= sy);
                  OPR_GTR: wdata <= 32'(sx > sy);
                  OPR_GEQ: wdata <= 32'(sx >= sy);
                  default: wdata <= res;
                endcase
              end
            end
            default: ;
          endcase
        end
        S_TOP: begin
          // let any write settle, then read top
          raddr <= sp;
          if (!we) state <= S_TOPW;
        end
        S_TOPW: state <= S_OUT;
        S_OUT: begin
          top_value <= rdata;
          if (bp == '0) stopped <= 1'b1;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign next_pc   = pc;
  assign base_now  = bp;
  assign top_index = sp;
  assign halted    = stopped;
  assign fault     = flt;
endmodule

// ===== rtl/pl0_chk.sv =====
`timescale 1ns / 1ps
module pl0_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        halted,
  input logic        write_valid,
  input logic        fault,
  input logic [31:0] write_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt cleared");
  a_wv: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> write_value == 32'd0) else $error("stray write value");
  a_wf: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> !fault) else $error("write on fault");
endmodule

bind pl0_stack_machine_execute pl0_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .halted(halted),
  .write_valid(write_valid), .fault(fault), .write_value(write_value)
);

// ===== sim/pl0_stack_machine_execute_tb.sv =====
`timescale 1ns / 1ps
module pl0_stack_machine_execute_tb;
  import pl0_pkg::*;

  localparam int SDEPTH = 2048;
  localparam int CDEPTH = 512;
  localparam int CYCLE_LIMIT = 600000;

  // expected outcome of one instruction
  typedef struct {
    logic [8:0]  pc;
    logic [10:0] bp;
    logic [10:0] sp;
    logic [31:0] tos;
    logic        wr_v;
    logic [31:0] wr_val;
    logic        halt;
    logic        flt;
  } exec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] opcode = '0;
  logic [1:0] level = '0;
  logic signed [31:0] modifier = '0;
  logic signed [31:0] read_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [8:0] next_pc;
  logic [10:0] base_now, top_index;
  logic signed [31:0] top_value, write_value;
  logic write_valid, halted, fault;

  // shadow machine state
  logic [31:0] mem_s [SDEPTH];
  logic [8:0]  pc_s;
  logic [10:0] bp_s, sp_s;
  logic        stop_s;

  exec_t exec_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;   // receiver long hold-off
  bit allow_halt = 1'b0;

  always #2 clk = ~clk;

  pl0_stack_machine_execute uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .level(level), .modifier(modifier), .read_value(read_value),
    .out_valid(out_valid), .out_ready(out_ready), .next_pc(next_pc),
    .base_now(base_now), .top_index(top_index), .top_value(top_value),
    .write_valid(write_valid), .write_value(write_value), .halted(halted), .fault(fault)
  );

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic bit in_stk(longint i);
    return i >= 0 && i < SDEPTH;
  endfunction

  function automatic bit in_code(longint a);
    return a >= 0 && a < CDEPTH;
  endfunction

  // execute one instruction on the shadow state
  function automatic exec_t exec_instr(logic [3:0] op, logic [1:0] lv, logic [31:0] mw,
                                       logic [31:0] rd);
    exec_t e;
    longint sp, bp, pc, b, t, r, m, a, y, sa, sb;
    logic [31:0] x, yv, res;
    bit bad, flt, wv, walk_ok;
    logic [31:0] wval;
    bad = 0; flt = 0; wv = 0; wval = '0;
    m = sx(mw);
    if (!stop_s) begin
      sp = sp_s; bp = bp_s; pc = pc_s + 1;
      if (pc >= CDEPTH) pc = 0;
      // static link walk, used by lod, sto and cal
      b = bp; walk_ok = 1;
      for (int k = 0; k < lv; k++) begin
        if (walk_ok) begin
          if (!in_stk(b) || !in_stk(b + 1)) walk_ok = 0;
          else b = sx(mem_s[b + 1]);
        end
      end
      if (!in_stk(b)) walk_ok = 0;
      case (op)
        OP_LIT, OP_RED: begin
          if (!in_stk(sp + 1)) bad = 1;
          else begin
            sp++;
            mem_s[sp] = (op == OP_LIT) ? mw : rd;
          end
        end
        OP_OPR: begin
          if (m == longint'(OPR_RET)) begin
            t = bp - 1;
            if (!in_stk(bp + 3) || !in_stk(t)) bad = 1;
            else begin
              r = sx(mem_s[bp + 3]);
              a = sx(mem_s[bp + 2]);
              if (!in_code(r) || !in_stk(a)) bad = 1;
              else begin
                sp = t; pc = r; bp = a;
              end
            end
          end else if (m == longint'(OPR_NEG)) begin
            mem_s[sp] = 32'd0 - mem_s[sp];
          end else if (m == longint'(OPR_ODD)) begin
            mem_s[sp] = mem_s[sp] & 32'd1;
          end else if (m >= 2 && m <= 13) begin
            if (!in_stk(sp - 1)) bad = 1;
            else begin
              x = mem_s[sp - 1]; yv = mem_s[sp];
              sa = sx(x); sb = sx(yv);
              res = '0;
              case (m[3:0])
                OPR_ADD: res = x + yv;
                OPR_SUB: res = x - yv;
                OPR_MUL: res = x * yv;
                OPR_DIV: begin
                  if (sb == 0) flt = 1;
                  else begin y = sa / sb; res = y[31:0]; end
                end
                OPR_MOD: begin
                  if (sb == 0) flt = 1;
                  else begin y = sa % sb; res = y[31:0]; end
                end
                OPR_EQL: res = {31'd0, sa == sb};
                OPR_NEQ: res = {31'd0, sa != sb};
                OPR_LSS: res = {31'd0, sa < sb};
                OPR_LEQ: res = {31'd0, sa <= sb};
                OPR_GTR: res = {31'd0, sa > sb};
                default: res = {31'd0, sa >= sb};
              endcase
              sp--;
              mem_s[sp] = res;
            end
          end
        end
        OP_LOD: begin
          if (!walk_ok || !in_stk(b + m) || !in_stk(sp + 1)) bad = 1;
          else begin
            sp++;
            mem_s[sp] = mem_s[b + m];
          end
        end
        OP_STO: begin
          if (!walk_ok || !in_stk(b + m) || !in_stk(sp - 1)) bad = 1;
          else begin
            mem_s[b + m] = mem_s[sp];
            sp--;
          end
        end
        OP_CAL: begin
          if (!walk_ok || !in_stk(sp + 4) || !in_code(m)) bad = 1;
          else begin
            mem_s[sp + 1] = '0;
            mem_s[sp + 2] = b[31:0];
            mem_s[sp + 3] = bp[31:0];
            mem_s[sp + 4] = pc[31:0];
            bp = sp + 1;
            pc = m;
          end
        end
        OP_INC: begin
          if (!in_stk(sp + m)) bad = 1;
          else sp += m;
        end
        OP_JMP: begin
          if (!in_code(m)) bad = 1;
          else pc = m;
        end
        OP_JPC: begin
          if (!in_stk(sp - 1)) bad = 1;
          else if (mem_s[sp] == 0 && !in_code(m)) bad = 1;
          else begin
            if (mem_s[sp] == 0) pc = m;
            sp--;
          end
        end
        OP_WRT: begin
          if (!in_stk(sp - 1)) bad = 1;
          else begin
            wv = 1;
            wval = mem_s[sp];
            sp--;
          end
        end
        default: ;
      endcase
      pc_s = pc[8:0];
      if (bad) flt = 1;
      else begin
        bp_s = bp[10:0];
        sp_s = sp[10:0];
      end
      if (bp_s == 0) stop_s = 1;
    end
    e.pc = pc_s; e.bp = bp_s; e.sp = sp_s; e.tos = mem_s[sp_s];
    e.wr_v = wv; e.wr_val = wv ? wval : 32'd0;
    e.halt = stop_s; e.flt = flt;
    return e;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (cycle %0d)", field, got, want, cycles);
  endtask

  // one instruction transaction
  task automatic send_instr(logic [3:0] op, logic [1:0] lv, logic [31:0] m, logic [31:0] rd);
    // keep random ret from halting the machine early
    if (!allow_halt && op == OP_OPR && m == 32'(OPR_RET) && bp_s + 2 < SDEPTH &&
        mem_s[bp_s + 2] == 0)
      m = 32'(OPR_ADD);
    exec_q.push_back(exec_instr(op, lv, m, rd));
    if (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op; level <= lv; modifier <= m; read_value <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver side: random stalls, plus the long hold-off on request
  always begin
    @(posedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      out_ready <= 1'b0;
      repeat (300) @(posedge clk);
    end
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // result checker
  always @(posedge clk) begin
    exec_t e;
    if (!rst && out_valid && out_ready) begin
      if (exec_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'd1, 32'd0);
      end else begin
        e = exec_q.pop_front();
        if (next_pc !== e.pc) report_mismatch("next_pc", 32'(next_pc), 32'(e.pc));
        if (base_now !== e.bp) report_mismatch("base_now", 32'(base_now), 32'(e.bp));
        if (top_index !== e.sp) report_mismatch("top_index", 32'(top_index), 32'(e.sp));
        if (top_value !== e.tos) report_mismatch("top_value", top_value, e.tos);
        if (write_valid !== e.wr_v) report_mismatch("write_valid", 32'(write_valid), 32'(e.wr_v));
        if (write_value !== e.wr_val) report_mismatch("write_value", write_value, e.wr_val);
        if (halted !== e.halt) report_mismatch("halted", 32'(halted), 32'(e.halt));
        if (fault !== e.flt) report_mismatch("fault", 32'(fault), 32'(e.flt));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pl0_stack_machine_execute_tb: errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_instr(OP_LIT, 0, 32'h7fffffff, 0);
    send_instr(OP_RED, 0, 0, 32'h80000000);
    send_instr(OP_OPR, 0, 32'(OPR_ADD), 0);
    send_instr(OP_LIT, 0, 32'h80000000, 0);
    send_instr(OP_LIT, 0, 32'hffffffff, 0);
    send_instr(OP_OPR, 0, 32'(OPR_DIV), 0);       // most negative over -1
    send_instr(OP_LIT, 0, 32'hffffffff, 0);
    send_instr(OP_OPR, 0, 32'(OPR_MOD), 0);
    send_instr(OP_LIT, 0, 0, 0);
    send_instr(OP_OPR, 0, 32'(OPR_DIV), 0);       // divide by zero
    send_instr(OP_LIT, 0, 32'hfffffff9, 0);
    send_instr(OP_OPR, 0, 32'(OPR_ODD), 0);       // odd on a negative value
    for (int s = 1; s <= 15; s++) begin
      send_instr(OP_LIT, 0, $urandom_range(0, 9) - 4, 0);
      send_instr(OP_OPR, 0, s, 0);
    end
    send_instr(OP_OPR, 0, 32'hffffffff, 0);       // unknown sub-operation
    send_instr(OP_STO, 0, 5, 0);
    send_instr(OP_LOD, 3, 5, 0);
    send_instr(OP_CAL, 1, 20, 0);
    send_instr(OP_INC, 0, 6, 0);
    send_instr(OP_LOD, 2, 1, 0);
    send_instr(OP_WRT, 0, 0, 0);
    send_instr(OP_OPR, 0, 32'(OPR_RET), 0);
    send_instr(OP_JPC, 0, 511, 0);
    send_instr(OP_LIT, 0, 1, 0);
    send_instr(OP_JPC, 0, 7, 0);
    send_instr(OP_JMP, 0, 512, 0);                // target out of range
    send_instr(OP_JMP, 0, 511, 0);
    send_instr(OP_INC, 0, 32'h80000000, 0);       // new sp out of range
    send_instr(OP_INC, 0, 2047 - sp_s, 0);
    send_instr(OP_LIT, 0, 3, 0);                  // stack overflow
    send_instr(OP_INC, 0, 32'(-int'(sp_s) + 2), 0);
    for (int o = 0; o < 16; o++)
      if (o == 0 || o > 10) send_instr(o[3:0], 3, 32'hffffffff, 32'hffffffff);
  endtask

  function automatic logic [31:0] rand_value();
    return ($urandom_range(1) == 0) ? $urandom() : 32'($urandom_range(0, 12)) - 32'd6;
  endfunction

  task automatic test_random(int n);
    int r;
    logic [31:0] m;
    logic [3:0] op;
    bit rare;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= 100 && i < 250);
      r = $urandom_range(99);
      rare = ($urandom_range(19) == 0);
      if (sp_s > 60 && r < 30) r = 92;
      if (sp_s < 2 || r < 25) begin
        op = ($urandom_range(3) == 0) ? OP_RED : OP_LIT;
        m = rand_value();
      end else if (r < 50) begin
        op = OP_OPR;
        m = rare ? $urandom() : 32'($urandom_range(0, 15));
      end else if (r < 60) begin
        op = OP_LOD;
        m = rare ? $urandom() : 32'($urandom_range(0, 8)) - 32'd2;
      end else if (r < 68) begin
        op = OP_STO;
        m = rare ? $urandom() : 32'($urandom_range(0, 8)) - 32'd2;
      end else if (r < 74) begin
        op = OP_CAL;
        m = rare ? $urandom() : 32'($urandom_range(0, 511));
      end else if (r < 80) begin
        op = OP_INC;
        m = rare ? $urandom() : 32'($urandom_range(0, 8)) - 32'd2;
      end else if (r < 85) begin
        op = OP_JMP;
        m = rare ? $urandom() : 32'($urandom_range(0, 511));
      end else if (r < 90) begin
        op = OP_JPC;
        m = rare ? $urandom() : 32'($urandom_range(0, 511));
      end else if (r < 97) begin
        op = OP_WRT;
        m = $urandom();
      end else begin
        op = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(11, 15));
        m = $urandom();
      end
      send_instr(op, 2'($urandom_range(0, 3)), m, $urandom());
    end
    quiet = 1'b0;
  endtask

  // receiver stops while the sender keeps offering transactions
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_instr(OP_LIT, 0, $urandom(), 0);
    for (int i = 0; i < 10; i++) send_instr(OP_WRT, 0, 0, 0);
  endtask

  // build a frame whose dynamic link is zero, return through it, then poke the frozen machine
  task automatic test_halt();
    allow_halt = 1'b1;
    if (sp_s < 4) send_instr(OP_INC, 0, 4, 0);
    send_instr(OP_LIT, 0, 0, 0);
    send_instr(OP_STO, 0, 2, 0);
    send_instr(OP_LIT, 0, 9, 0);
    send_instr(OP_STO, 0, 3, 0);
    send_instr(OP_OPR, 0, 32'(OPR_RET), 0);
    send_instr(OP_LIT, 0, 1, 0);
    send_instr(OP_WRT, 0, 0, 0);
    send_instr(OP_OPR, 0, 32'(OPR_DIV), 0);
    send_instr(OP_JMP, 0, 600, 0);
  endtask

  initial begin
    for (int i = 0; i < SDEPTH; i++) mem_s[i] = '0;
    pc_s = '0; bp_s = 11'd1; sp_s = '0; stop_s = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500);
    test_backpressure();
    test_halt();
    in_valid <= 1'b0;
    while (exec_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && exec_q.size() == 0)
      $display("pl0_stack_machine_execute_tb: clean");
    else
      $display("pl0_stack_machine_execute_tb: errors");
    $finish;
  end
endmodule
